### hw/rtl/plp_pkg.sv
// ----------------------------------------------------------------------------
// plp_pkg: shared types and constants for the lookahead point block
// Operation and status codes, register indexes and fixed datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package plp_pkg;

  // Field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned StW    = 2;
  localparam int unsigned LaW    = 31;
  localparam int unsigned StepW  = 17;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_BAD    = 2'd3
  } op_e;

  // Status codes
  localparam logic [StW-1:0] ST_OK   = 2'd0;
  localparam logic [StW-1:0] ST_GOAL = 2'd1;
  localparam logic [StW-1:0] ST_ERR  = 2'd2;

  // Register indexes
  localparam logic REG_LOOKAHEAD = 1'b0;
  localparam logic REG_STEP      = 1'b1;

  // Reset values of the registers
  localparam logic [LaW-1:0]   LA_RESET   = 31'd65536;
  localparam logic [StepW-1:0] STEP_RESET = 17'd6554;

  // Interpolation step cap and datapath widths
  localparam int unsigned StepCntW  = 11;
  localparam logic [StepCntW-1:0] STEP_LIMIT = 11'd1024;
  localparam int unsigned MagW   = 33;   // magnitude of a coordinate difference
  localparam int unsigned ProdW  = 66;   // shared multiplier product
  localparam int unsigned NumW   = 67;   // dividend of the serial divider
  localparam int unsigned DvsW   = 34;   // divisor and partial remainder
  localparam int unsigned SqRemW = 35;   // partial remainder of the root unit
  localparam int unsigned CntW   = 7;    // iteration counter
  localparam logic [CntW-1:0] DIV_ITERS  = 7'd67;
  localparam logic [CntW-1:0] SQRT_ITERS = 7'd33;

endpackage

`default_nettype wire

### hw/rtl/plp_in_if.sv
// ----------------------------------------------------------------------------
// plp_in_if: request channel of the lookahead point block
// Valid/ready channel carrying an operation and a position.
// ----------------------------------------------------------------------------
`default_nettype none

interface plp_in_if;
  logic                              valid;
  logic                              ready;
  logic [plp_pkg::OpW-1:0]           op;
  logic signed [plp_pkg::CoordW-1:0] pos_x;
  logic signed [plp_pkg::CoordW-1:0] pos_y;

  modport source (output valid, output op, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input op, input pos_x, input pos_y, output ready);
endinterface

`default_nettype wire

### hw/rtl/plp_out_if.sv
// ----------------------------------------------------------------------------
// plp_out_if: response channel of the lookahead point block
// Valid/ready channel carrying the local goal and a status code.
// ----------------------------------------------------------------------------
`default_nettype none

interface plp_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [plp_pkg::CoordW-1:0] goal_x;
  logic signed [plp_pkg::CoordW-1:0] goal_y;
  logic [plp_pkg::IdxW-1:0]          goal_idx;
  logic [plp_pkg::StW-1:0]           status;

  modport source (output valid, output goal_x, output goal_y, output goal_idx,
                  output status, input ready);
  modport sink   (input valid, input goal_x, input goal_y, input goal_idx,
                  input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/path_lookahead_point.sv
// ----------------------------------------------------------------------------
// path_lookahead_point: local goal point on a stored polyline path
// Stores a path point by point and answers position queries with a goal
// found by a forward scan and a backward interpolation walk.
// ----------------------------------------------------------------------------
// Usage:
//   req_i takes op/pos_x/pos_y. Clear and append go straight to the response
//   register. A query scans the path from the remembered index point by point
//   (a point where one axis alone reaches the radius is taken without the
//   squared distance), computes the segment length (square root) and the step
//   count (division), then walks the interpolation steps (two divisions plus a
//   distance check each). All products go through one 33x33 multiplier and
//   all quotients through one radix-2 divider, so those two units set the
//   time of a query.
//   req_i.ready is high only while the sequencer is idle; one item is in
//   work at a time.
//   rsp_o is an output register: a finished result waits there while the
//   next request is taken; a new result is held back until it is taken.
//   The user writes registers over the APB port only while the block is idle;
//   the block does not enforce it. Reset empties the path, clears the search
//   index and loads the register defaults; no clearing pass is needed since
//   entries at or above the point count are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module path_lookahead_point #(
  parameter int unsigned MAX_PATH_POINTS = 256
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  plp_in_if.sink     req_i,
  plp_out_if.source  rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int unsigned AW = (MAX_PATH_POINTS > 1) ? $clog2(MAX_PATH_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_PATH_POINTS + 1);

  // Sequencer states
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQL   = 5'd1;
  localparam logic [4:0] S_L2    = 5'd2;
  localparam logic [4:0] S_SRD   = 5'd3;
  localparam logic [4:0] S_SDIF  = 5'd4;
  localparam logic [4:0] S_GCHK  = 5'd5;
  localparam logic [4:0] S_DM1   = 5'd6;
  localparam logic [4:0] S_DM2   = 5'd7;
  localparam logic [4:0] S_DM3   = 5'd8;
  localparam logic [4:0] S_FRD   = 5'd9;
  localparam logic [4:0] S_FCAP  = 5'd10;
  localparam logic [4:0] S_BCAP  = 5'd11;
  localparam logic [4:0] S_SM1   = 5'd12;
  localparam logic [4:0] S_SM2   = 5'd13;
  localparam logic [4:0] S_SM3   = 5'd14;
  localparam logic [4:0] S_SQRT  = 5'd15;
  localparam logic [4:0] S_NDIV  = 5'd16;
  localparam logic [4:0] S_DIV   = 5'd17;
  localparam logic [4:0] S_DDONE = 5'd18;
  localparam logic [4:0] S_KX    = 5'd19;
  localparam logic [4:0] S_KXD   = 5'd20;
  localparam logic [4:0] S_KY    = 5'd21;
  localparam logic [4:0] S_KYD   = 5'd22;
  localparam logic [4:0] S_NEXT  = 5'd23;
  localparam logic [4:0] S_OUT   = 5'd24;

  // Divider phases and distance check modes
  localparam logic [1:0] PH_N = 2'd0;
  localparam logic [1:0] PH_X = 2'd1;
  localparam logic [1:0] PH_Y = 2'd2;
  localparam logic MD_SCAN = 1'b0;
  localparam logic MD_STEP = 1'b1;

  // Control state
  logic [4:0]                     state_q, state_d;
  logic [CW-1:0]                  path_cnt_q;
  logic [AW-1:0]                  search_q;
  logic                           out_vld_q;
  logic [plp_pkg::LaW-1:0]        la_q;
  logic [plp_pkg::StepW-1:0]      step_q;

  // Path memory
  logic [plp_pkg::CoordW-1:0] x_mem [MAX_PATH_POINTS];
  logic [plp_pkg::CoordW-1:0] y_mem [MAX_PATH_POINTS];
  logic [AW-1:0]              rd_addr;
  logic signed [plp_pkg::CoordW-1:0] x_rd_q, y_rd_q;

  // Datapath registers
  logic signed [plp_pkg::CoordW-1:0] px_q, py_q, fx_q, fy_q, gx_q, gy_q;
  logic [CW-1:0]                idx_q;
  logic [AW-1:0]                found_q;
  logic [plp_pkg::MagW-1:0]     ax_q, ay_q, dax_q, day_q, d_q, k_q;
  logic                         sx_q, sy_q, mode_q;
  logic [1:0]                   ph_q;
  logic [61:0]                  l2_q;
  logic [plp_pkg::ProdW-1:0]    mul_q, acc_q;
  logic [plp_pkg::ProdW-1:0]    sq_val_q;
  logic [plp_pkg::SqRemW-1:0]   sq_rem_q;
  logic [plp_pkg::MagW-1:0]     rt_q;
  logic [plp_pkg::NumW-1:0]     num_q;
  logic [plp_pkg::DvsW-1:0]     dvs_q, drem_q;
  logic [plp_pkg::CntW-1:0]     cnt_q;
  logic [plp_pkg::StepCntW-1:0] n_q, i_q;
  logic [plp_pkg::StW-1:0]      res_st_q;

  // Output register
  logic signed [plp_pkg::CoordW-1:0] out_x_q, out_y_q;
  logic [plp_pkg::IdxW-1:0]          out_idx_q;
  logic [plp_pkg::StW-1:0]           out_st_q;

  // Combinational helpers
  logic                         req_xfer, out_load;
  logic [plp_pkg::StepW-1:0]    s_eff;
  logic [plp_pkg::MagW-1:0]     l_ext, ax_c, ay_c, mul_a, mul_b, dax_c, day_c;
  logic signed [plp_pkg::CoordW-1:0] src_x, src_y;
  logic signed [plp_pkg::MagW-1:0]   dfx, dfy, dbx, dby;
  logic                         big_ge, big_gt;
  logic [plp_pkg::ProdW-1:0]    dsum;
  logic [plp_pkg::SqRemW+1:0]   sq_r2, sq_tr;
  logic                         sq_ge;
  logic [plp_pkg::DvsW:0]       dv_t;
  logic                         dv_ge;
  logic [plp_pkg::StepCntW-1:0] nsat;
  logic signed [plp_pkg::MagW-1:0] f33, gnew;
  logic                         g_sgn;
  logic [AW+7:0]                fidx_ext;
  logic [AW-1:0]                found_m1;

  assign req_xfer = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_load = (state_q == S_OUT) && (!out_vld_q || rsp_o.ready);
  assign s_eff = (step_q == '0) ? plp_pkg::StepW'(1) : step_q;
  assign l_ext = {2'b00, la_q};

  // Distance of a stored point or a step point from the robot
  assign src_x = (state_q == S_SDIF) ? x_rd_q : gx_q;
  assign src_y = (state_q == S_SDIF) ? y_rd_q : gy_q;
  assign dfx   = {src_x[31], src_x} - {px_q[31], px_q};
  assign dfy   = {src_y[31], src_y} - {py_q[31], py_q};
  assign ax_c  = dfx[32] ? plp_pkg::MagW'(-dfx) : plp_pkg::MagW'(dfx);
  assign ay_c  = dfy[32] ? plp_pkg::MagW'(-dfy) : plp_pkg::MagW'(dfy);
  assign big_ge = (ax_c >= l_ext) || (ay_c >= l_ext);
  assign big_gt = (ax_c > l_ext) || (ay_c > l_ext);
  assign dsum  = acc_q + mul_q;

  // Segment difference, previous point minus found point
  assign dbx   = {x_rd_q[31], x_rd_q} - {fx_q[31], fx_q};
  assign dby   = {y_rd_q[31], y_rd_q} - {fy_q[31], fy_q};
  assign dax_c = dbx[32] ? plp_pkg::MagW'(-dbx) : plp_pkg::MagW'(dbx);
  assign day_c = dby[32] ? plp_pkg::MagW'(-dby) : plp_pkg::MagW'(dby);

  // Square root step: two radicand bits per cycle
  assign sq_r2 = {sq_rem_q, sq_val_q[plp_pkg::ProdW-1 -: 2]};
  assign sq_tr = {2'b00, rt_q, 2'b01};
  assign sq_ge = (sq_r2 >= sq_tr);

  // Divider step: one quotient bit per cycle
  assign dv_t  = {drem_q, num_q[plp_pkg::NumW-1]};
  assign dv_ge = (dv_t >= {1'b0, dvs_q});

  // Step count, capped
  assign nsat = (num_q > plp_pkg::NumW'(plp_pkg::STEP_LIMIT)) ? plp_pkg::STEP_LIMIT
                                                               : num_q[plp_pkg::StepCntW-1:0];

  // Step point coordinate from the rounded offset
  assign f33   = (ph_q == PH_X) ? {fx_q[31], fx_q} : {fy_q[31], fy_q};
  assign g_sgn = (ph_q == PH_X) ? sx_q : sy_q;
  assign gnew  = g_sgn ? (f33 - $signed(num_q[plp_pkg::MagW-1:0]))
                       : (f33 + $signed(num_q[plp_pkg::MagW-1:0]));

  assign fidx_ext = {8'd0, found_q};
  assign found_m1 = found_q - AW'(1);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_SQL:   begin mul_a = l_ext; mul_b = l_ext; end
      S_DM1:   begin mul_a = ax_q;  mul_b = ax_q;  end
      S_DM2:   begin mul_a = ay_q;  mul_b = ay_q;  end
      S_SM1:   begin mul_a = dax_q; mul_b = dax_q; end
      S_SM2:   begin mul_a = day_q; mul_b = day_q; end
      S_KX:    begin mul_a = dax_q; mul_b = k_q;   end
      S_KY:    begin mul_a = day_q; mul_b = k_q;   end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  // Memory read address
  always_comb begin
    unique case (state_q)
      S_FRD:   rd_addr = found_q;
      S_FCAP:  rd_addr = found_m1;
      default: rd_addr = idx_q[AW-1:0];
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          if (req_i.op == plp_pkg::OP_QUERY && path_cnt_q >= CW'(2)) state_d = S_SQL;
          else state_d = S_OUT;
        end
      end
      S_SQL:  state_d = S_L2;
      S_L2:   state_d = S_SRD;
      S_SRD:  state_d = (idx_q >= path_cnt_q) ? S_FRD : S_SDIF;
      S_SDIF: state_d = big_ge ? S_FRD : S_DM1;
      S_GCHK: state_d = big_gt ? S_NEXT : S_DM1;
      S_DM1:  state_d = S_DM2;
      S_DM2:  state_d = S_DM3;
      S_DM3: begin
        if (mode_q == MD_SCAN) state_d = (dsum >= {4'd0, l2_q}) ? S_FRD : S_SRD;
        else state_d = (dsum <= {4'd0, l2_q}) ? S_OUT : S_NEXT;
      end
      S_FRD:  state_d = S_FCAP;
      S_FCAP: state_d = (found_q == '0) ? S_OUT : S_BCAP;
      S_BCAP: state_d = S_SM1;
      S_SM1:  state_d = S_SM2;
      S_SM2:  state_d = S_SM3;
      S_SM3:  state_d = S_SQRT;
      S_SQRT: state_d = (cnt_q == plp_pkg::CntW'(1)) ? S_NDIV : S_SQRT;
      S_NDIV: state_d = S_DIV;
      S_DIV:  state_d = (cnt_q == plp_pkg::CntW'(1)) ? S_DDONE : S_DIV;
      S_DDONE: begin
        unique case (ph_q)
          PH_N:    state_d = (nsat == '0) ? S_OUT : S_KX;
          PH_X:    state_d = S_KY;
          default: state_d = S_GCHK;
        endcase
      end
      S_KX:   state_d = S_KXD;
      S_KXD:  state_d = S_DIV;
      S_KY:   state_d = S_KYD;
      S_KYD:  state_d = S_DIV;
      S_NEXT: state_d = (i_q == n_q) ? S_OUT : S_KX;
      S_OUT:  state_d = out_load ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      path_cnt_q <= '0;
      search_q   <= '0;
      out_vld_q  <= 1'b0;
      la_q       <= plp_pkg::LA_RESET;
      step_q     <= plp_pkg::STEP_RESET;
    end else begin
      state_q <= state_d;
      // clear or extend the path
      if (req_xfer && req_i.op == plp_pkg::OP_CLEAR) begin
        path_cnt_q <= '0;
        search_q   <= '0;
      end else if (req_xfer && req_i.op == plp_pkg::OP_APPEND
                   && path_cnt_q < CW'(MAX_PATH_POINTS)) begin
        path_cnt_q <= path_cnt_q + CW'(1);
      end
      // remember the found index for the next search
      if (state_q == S_FRD) search_q <= found_q;
      // hand over to the response register
      if (out_load) out_vld_q <= 1'b1;
      else if (rsp_o.ready) out_vld_q <= 1'b0;
      // register writes
      if (psel && penable && pwrite) begin
        if (paddr[2] == plp_pkg::REG_LOOKAHEAD) la_q <= pwdata[plp_pkg::LaW-1:0];
        else step_q <= pwdata[plp_pkg::StepW-1:0];
      end
    end
  end

  // Path memory write and registered read
  always_ff @(posedge clk_i) begin
    if (req_xfer && req_i.op == plp_pkg::OP_APPEND && path_cnt_q < CW'(MAX_PATH_POINTS)) begin
      x_mem[path_cnt_q[AW-1:0]] <= req_i.pos_x;
      y_mem[path_cnt_q[AW-1:0]] <= req_i.pos_y;
    end
    x_rd_q <= x_mem[rd_addr];
    y_rd_q <= y_mem[rd_addr];
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    unique case (state_q)
      S_IDLE: begin
        px_q  <= req_i.pos_x;
        py_q  <= req_i.pos_y;
        idx_q <= CW'(search_q);
        if (req_i.op == plp_pkg::OP_CLEAR) res_st_q <= plp_pkg::ST_OK;
        else if (req_i.op == plp_pkg::OP_APPEND)
          res_st_q <= (path_cnt_q < CW'(MAX_PATH_POINTS)) ? plp_pkg::ST_OK : plp_pkg::ST_ERR;
        else if (req_i.op == plp_pkg::OP_QUERY && path_cnt_q >= CW'(2))
          res_st_q <= plp_pkg::ST_GOAL;
        else res_st_q <= plp_pkg::ST_ERR;
        mode_q <= MD_SCAN;
      end
      S_L2: l2_q <= mul_q[61:0];
      S_SRD: begin
        if (idx_q >= path_cnt_q) found_q <= AW'(path_cnt_q - CW'(1));
      end
      S_SDIF, S_GCHK: begin
        ax_q <= ax_c;
        ay_q <= ay_c;
        if (state_q == S_SDIF && big_ge) found_q <= idx_q[AW-1:0];
      end
      S_DM2: acc_q <= mul_q;
      S_DM3: begin
        if (mode_q == MD_SCAN) begin
          if (dsum >= {4'd0, l2_q}) found_q <= idx_q[AW-1:0];
          else idx_q <= idx_q + CW'(1);
        end
      end
      S_FCAP: begin
        fx_q <= x_rd_q;
        fy_q <= y_rd_q;
        gx_q <= x_rd_q;
        gy_q <= y_rd_q;
      end
      S_BCAP: begin
        dax_q  <= dax_c;
        day_q  <= day_c;
        sx_q   <= dbx[32];
        sy_q   <= dby[32];
        mode_q <= MD_STEP;
      end
      S_SM2: acc_q <= mul_q;
      S_SM3: begin
        sq_val_q <= dsum;
        sq_rem_q <= '0;
        rt_q     <= '0;
        cnt_q    <= plp_pkg::SQRT_ITERS;
      end
      S_SQRT: begin
        sq_val_q <= {sq_val_q[plp_pkg::ProdW-3:0], 2'b00};
        if (sq_ge) begin
          sq_rem_q <= plp_pkg::SqRemW'(sq_r2 - sq_tr);
          rt_q     <= {rt_q[plp_pkg::MagW-2:0], 1'b1};
        end else begin
          sq_rem_q <= sq_r2[plp_pkg::SqRemW-1:0];
          rt_q     <= {rt_q[plp_pkg::MagW-2:0], 1'b0};
        end
        cnt_q <= cnt_q - plp_pkg::CntW'(1);
      end
      S_NDIV: begin
        d_q    <= rt_q;
        num_q  <= plp_pkg::NumW'(rt_q);
        dvs_q  <= plp_pkg::DvsW'(s_eff);
        drem_q <= '0;
        cnt_q  <= plp_pkg::DIV_ITERS;
        ph_q   <= PH_N;
      end
      S_DIV: begin
        drem_q <= dv_ge ? plp_pkg::DvsW'(dv_t - {1'b0, dvs_q}) : dv_t[plp_pkg::DvsW-1:0];
        num_q  <= {num_q[plp_pkg::NumW-2:0], dv_ge};
        cnt_q  <= cnt_q - plp_pkg::CntW'(1);
      end
      S_DDONE: begin
        unique case (ph_q)
          PH_N: begin
            n_q <= nsat;
            i_q <= plp_pkg::StepCntW'(1);
            k_q <= plp_pkg::MagW'(s_eff);
          end
          PH_X:    gx_q <= gnew[plp_pkg::CoordW-1:0];
          default: gy_q <= gnew[plp_pkg::CoordW-1:0];
        endcase
      end
      S_KXD, S_KYD: begin
        num_q  <= plp_pkg::NumW'(mul_q) + plp_pkg::NumW'(d_q >> 1);
        dvs_q  <= plp_pkg::DvsW'(d_q);
        drem_q <= '0;
        cnt_q  <= plp_pkg::DIV_ITERS;
        ph_q   <= (state_q == S_KXD) ? PH_X : PH_Y;
      end
      S_NEXT: begin
        i_q <= i_q + plp_pkg::StepCntW'(1);
        k_q <= k_q + plp_pkg::MagW'(s_eff);
      end
      default: begin
      end
    endcase
    // load the response register
    if (out_load) begin
      out_st_q <= res_st_q;
      if (res_st_q == plp_pkg::ST_GOAL) begin
        out_x_q   <= gx_q;
        out_y_q   <= gy_q;
        out_idx_q <= fidx_ext[7:0];
      end else begin
        out_x_q   <= '0;
        out_y_q   <= '0;
        out_idx_q <= '0;
      end
    end
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.goal_x   = out_x_q;
  assign rsp_o.goal_y   = out_y_q;
  assign rsp_o.goal_idx = out_idx_q;
  assign rsp_o.status   = out_st_q;

  // Register read back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == plp_pkg::REG_LOOKAHEAD) ? {1'b0, la_q} : {15'd0, step_q};

  // Checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(path_cnt_q) <= MAX_PATH_POINTS)
    else $error("point count above capacity");

  a_search_in_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    path_cnt_q != '0 |-> CW'(search_q) < path_cnt_q)
    else $error("search index outside the path");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_vld_q && !rsp_o.ready |=> state_q == S_OUT)
    else $error("result dropped while the response is stalled");

endmodule

`default_nettype wire
